FILE: hdl/weat_pkg.sv
// Weekly event alarm table: shared types, status and op codes, time helpers.
// No dependencies; imported by the table core.
package weat_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Register index of the enable bit (byte address 4 * index)
    localparam logic REG_ENABLE = 1'b0;

    localparam int unsigned MIN_PER_DAY  = 1440;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam logic [13:0] MIN_PER_WEEK = 14'd10080;
    localparam logic [2:0]  DAY_MAX      = 3'd6;
    localparam logic [4:0]  HOUR_MAX     = 5'd23;
    localparam logic [5:0]  MINUTE_MAX   = 6'd59;

    // One table entry, day in the lowest bits
    typedef struct packed {
        logic       action;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] day;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    function automatic logic fields_ok(input logic [2:0] d, input logic [4:0] h,
                                       input logic [5:0] m);
        fields_ok = (d <= DAY_MAX) && (h <= HOUR_MAX) && (m <= MINUTE_MAX);
    endfunction

    // Minute of the week: day * 1440 + hour * 60 + minute
    function automatic logic [13:0] week_min(input logic [2:0] d, input logic [4:0] h,
                                             input logic [5:0] m);
        week_min = 14'(14'(d) * 14'(MIN_PER_DAY)) + 14'(14'(h) * 14'(MIN_PER_HOUR))
                 + 14'(m);
    endfunction

endpackage

FILE: hdl/weat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the alarm entries of the table core.
module weat_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/weekly_event_alarm_table_core.sv
// Weekly event alarm table: entry store, add/delete/tick sequencer, APB enable register.
// Depends on weat_pkg and weat_ram.
//
// Usage: items enter on the slave stream (tuser = op, tdata = day/hour/minute/action);
// each item gives exactly one result beat on the master stream. The APB port holds
// one register, enable, at byte address 0.
// Add and delete walk the stored entries once through the RAM read port looking for
// an exact match; a tick walks them once, firing the first entry at the current minute
// and tracking the nearest future entry through one shared subtract/compare unit.
// Invalid, full, unknown-op and disabled-tick items skip the walk and go straight to the finish state.
// A delete that hits then moves the later entries down one per cycle.
// Only one item is in flight: tready is high only while the sequencer is idle.
// The result sits in an output register, so the next item can be accepted while a
// result still waits; the sequencer holds its finished result until that register
// frees up when the receiver stalls.
// Reset clears the entry count, the last-fired mark, enable and the output valid;
// table contents are left as they are and are never read before being rewritten.
module weekly_event_alarm_table_core
    import weat_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input beat
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // day[2:0], hour[7:3], minute[13:8], action[14]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // Result beat
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // status[2:0], fired[3], fired_action[4],
                                          // seconds_to_next[24:5], entry_count[29:25]
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_en;
    logic            r_lfv, n_lfv;
    logic [13:0]     r_lft, n_lft;
    logic            r_pv, n_pv;
    logic            r_ovalid, n_ovalid;

    // Per-item working registers
    logic [1:0]      r_op, n_op;
    t_entry          r_ent, n_ent;
    logic [13:0]     r_now, n_now;
    logic [13:0]     r_wrap, n_wrap;
    logic            r_supp, n_supp;
    logic [CW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic            r_found, n_found;
    logic [CW-1:0]   r_pos, n_pos;
    logic            r_fact, n_fact;
    logic [13:0]     r_best, n_best;
    logic [2:0]      r_status, n_status;
    logic            r_fired, n_fired;
    logic [19:0]     r_secs, n_secs;
    logic [31:0]     r_odata, n_odata;

    // RAM ports
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic [IW-1:0]   ram_raddr;
    t_entry          ram_rdata;

    // Shared unit and helpers
    t_entry          in_ent;
    logic            in_ok;
    logic [13:0]     in_now;
    logic [13:0]     ev;
    logic [13:0]     diff;
    logic            walk_more;
    logic            walk_done;
    logic            s_acc;
    logic            cfg_wr;

    weat_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_ent   = t_entry'(i_s_axis_tdata[14:0]);
    assign in_ok    = fields_ok(in_ent.day, in_ent.hour, in_ent.minute);
    assign in_now   = week_min(in_ent.day, in_ent.hour, in_ent.minute);
    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;

    assign walk_more = (r_idx < r_count);
    assign walk_done = !walk_more && !r_pv;

    // Distance in minutes from now to the entry just read; same minute wraps a full week
    assign ev   = week_min(ram_rdata.day, ram_rdata.hour, ram_rdata.minute);
    assign diff = (ev > r_now) ? (ev - r_now) : (r_wrap + ev);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lfv    = r_lfv;
        n_lft    = r_lft;
        n_pv     = 1'b0;
        n_ovalid = r_ovalid;
        n_op     = r_op;
        n_ent    = r_ent;
        n_now    = r_now;
        n_wrap   = r_wrap;
        n_supp   = r_supp;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_found  = r_found;
        n_pos    = r_pos;
        n_fact   = r_fact;
        n_best   = r_best;
        n_status = r_status;
        n_fired  = r_fired;
        n_secs   = r_secs;
        n_odata  = r_odata;

        ram_we    = 1'b0;
        ram_waddr = r_pidx - IW'(1);
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[IW-1:0];

        // Drop the result beat once taken
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_op     = i_s_axis_tuser;
                    n_ent    = in_ent;
                    n_now    = in_now;
                    n_wrap   = MIN_PER_WEEK - in_now;
                    n_supp   = r_lfv && (r_lft == in_now);
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_fact   = 1'b0;
                    n_best   = MIN_PER_WEEK;
                    n_status = ST_DONE;
                    n_fired  = 1'b0;
                    n_secs   = '0;
                    n_state  = S_FINISH;
                    case (i_s_axis_tuser)
                        OP_ADD: begin
                            if (r_count >= MAX_CNT) begin
                                n_status = ST_FULL;
                            end else if (!in_ok) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_DELETE: begin
                            if (!in_ok) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_TICK: begin
                            if (!in_ok) begin
                                n_status = ST_INVALID;
                            end else if (r_en) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue the next read; evaluate the entry read last cycle
                if (walk_more) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                    n_idx  = r_idx + CW'(1);
                end
                if (r_pv) begin
                    if (r_op == OP_TICK) begin
                        if (!r_found && !r_supp && ram_rdata.day == r_ent.day &&
                            ram_rdata.hour == r_ent.hour && ram_rdata.minute == r_ent.minute) begin
                            n_found = 1'b1;
                            n_fact  = ram_rdata.action;
                        end
                        if (diff < r_best) begin
                            n_best = diff;
                        end
                    end else if (!r_found && ram_rdata == r_ent) begin
                        n_found = 1'b1;
                        n_pos   = CW'(r_pidx);
                    end
                end
                if (walk_done) begin
                    n_state = S_FINISH;
                    case (r_op)
                        OP_ADD: begin
                            if (r_found) begin
                                n_status = ST_PRESENT;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[IW-1:0];
                                ram_wdata = r_ent;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (r_found) begin
                                n_idx   = r_pos + CW'(1);
                                n_state = S_SHIFT;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (r_found) begin
                                n_fired = 1'b1;
                                n_lfv   = 1'b1;
                                n_lft   = r_now;
                            end
                            if (r_count != '0) begin
                                // minutes * 60 = minutes * 64 - minutes * 4
                                n_secs = (20'(r_best) << 6) - (20'(r_best) << 2);
                            end
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // Move entry j down to j - 1 for every entry past the hit
                if (walk_more) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                    n_idx  = r_idx + CW'(1);
                end
                if (r_pv) begin
                    ram_we = 1'b1;
                end
                if (walk_done) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FINISH;
                end
            end

            S_FINISH: begin
                // Hold until the output register is free
                if (!r_ovalid || i_m_axis_tready) begin
                    n_odata  = {2'b00, 5'(r_count), r_secs, r_fact & r_fired, r_fired,
                                r_status};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_en     <= 1'b0;
            r_lfv    <= 1'b0;
            r_lft    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_lfv    <= n_lfv;
            r_lft    <= n_lft;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
            if (cfg_wr && paddr[2] == REG_ENABLE) begin
                r_en <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_ent    <= n_ent;
        r_now    <= n_now;
        r_wrap   <= n_wrap;
        r_supp   <= n_supp;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_fact   <= n_fact;
        r_best   <= n_best;
        r_status <= n_status;
        r_fired  <= n_fired;
        r_secs   <= n_secs;
        r_odata  <= n_odata;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_ENABLE) ? {31'd0, r_en} : 32'd0;

    // The table never holds more entries than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("entry count exceeds table size");

    // One item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("input accepted while item in flight");

    // A fired result always carries done status
    a_fire_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[3]) |-> (o_m_axis_tdata[2:0] == ST_DONE))
        else $error("fired result without done status");

    // Seconds to next never exceed one week
    a_secs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[24:5] <= 20'd604800))
        else $error("seconds_to_next beyond one week");

    // A fire marks the minute so the same minute cannot fire again
    a_fire_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && walk_done && r_op == OP_TICK && r_found) |=>
        (r_lfv && r_lft == r_now))
        else $error("fire did not record last-fired time");

endmodule
